@@ hw/rtl/rrab_pkg.sv @@
// Package for the rounded rectangle alpha blender.
// Holds widths, register indexes, color masks and the per-pixel pipeline record.
// Used by rounded_rect_alpha_blend.
`default_nettype none
package rrab_pkg;
	localparam int COORD_BITS = 12;
	localparam int HALF_BITS  = COORD_BITS - 1;
	localparam int SQ_W       = COORD_BITS + 1;          // root of dx*dx + dy*dy
	localparam int SUM_W      = 2 * COORD_BITS + 2;      // remainder width
	localparam int TRY_W      = SUM_W + 1;
	localparam int SQ_STEPS   = 4;                       // root bits per stage
	localparam int SQ_STAGES  = (SQ_W + SQ_STEPS - 1) / SQ_STEPS;
	localparam int SHAPE_W    = SQ_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = ((2 * COORD_BITS + 32 + 7) / 8) * 8;

	localparam logic [31:0] RB_MASK  = 32'h00FF00FF;
	localparam logic [31:0] G_MASK   = 32'h0000FF00;
	localparam logic [31:0] ALPHA_FF = 32'hFF000000;
	localparam logic [7:0]  ALPHA_FULL = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECT_WIDTH  = 3'd0,
		REG_RECT_HEIGHT = 3'd1,
		REG_RADIUS      = 3'd2,
		REG_BORDER      = 3'd3,
		REG_FILL_COLOR  = 3'd4,
		REG_EDGE_COLOR  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                  in_range;
		logic                  sq_edge;
		logic                  both_pos;
		logic [COORD_BITS-1:0] dmax;
		logic [31:0]           dst;
	} pix_t;
endpackage
`default_nettype wire

@@ hw/rtl/rounded_rect_alpha_blend.sv @@
// Rounded rectangle shader with alpha blend over ARGB8888 destination pixels.
// Depends on rrab_pkg.
//
// Usage:
//   Slave channel s_*: one pixel item per handshake, offset and destination.
//   Master channel m_*: one result item per input item, in input order;
//   m_tuser is the write enable, m_tdata the blended pixel (0 when no write).
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr at the
//   clock edge; write only while the pipeline is empty.
// Throughput is one item per cycle while m_tready is high. There are ten
// register stages, among them those of the corner square root, which resolves
// four root bits per stage over four stages, and those of the two registered
// multiplies (distance squares, lane blend).
// Each stage has its own valid bit and moves when the stage after it is free,
// so empty stages fill while m_tready is low and nothing is lost or repeated.
// Reset clears all valid bits and configuration registers to zero.
`default_nettype none
module rounded_rect_alpha_blend (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rrab_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [rrab_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// offset_x, offset_y, dest_pixel from bit 0 up, zero padded
	input  wire logic [rrab_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// new_pixel
	output logic [31:0]                        m_tdata,
	// write_enable
	output logic                               m_tuser
);
	import rrab_pkg::*;

	localparam int NST = 10;
	localparam int SQ0 = 4;   // first square root stage

	logic [COORD_BITS-1:0] rect_width_q, rect_height_q;
	logic [HALF_BITS-1:0]  radius_q, border_q;
	logic [31:0]           fill_q, edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_width_q  <= '0;
			rect_height_q <= '0;
			radius_q      <= '0;
			border_q      <= '0;
			fill_q        <= '0;
			edge_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RECT_WIDTH:  rect_width_q  <= cfg_wdata[COORD_BITS-1:0];
				REG_RECT_HEIGHT: rect_height_q <= cfg_wdata[COORD_BITS-1:0];
				REG_RADIUS:      radius_q      <= cfg_wdata[HALF_BITS-1:0];
				REG_BORDER:      border_q      <= cfg_wdata[HALF_BITS-1:0];
				REG_FILL_COLOR:  fill_q        <= cfg_wdata[31:0];
				REG_EDGE_COLOR:  edge_q        <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// stage valid bits and advance chain
	logic [NST:1]   vld_s;
	logic [NST+1:1] adv;

	always_comb begin
		adv[NST+1] = m_tready;
		for (int k = NST; k >= 1; k--) adv[k] = !vld_s[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) vld_s[1] <= s_tvalid;
			for (int k = 2; k <= NST; k++) if (adv[k]) vld_s[k] <= vld_s[k-1];
		end
	end

	assign s_tready = adv[1];

	// ---------------- stage 1: axis distances, square-mode border
	logic [COORD_BITS-1:0] cx, cy, dx_c, dy_c, mx, my, mm;
	logic [COORD_BITS:0]   cxr, cyr;
	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	pix_t                  pix_c, pix_s1;

	assign cx  = s_tdata[COORD_BITS-1:0];
	assign cy  = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign cxr = {1'b0, cx} + (COORD_BITS+1)'(radius_q);
	assign cyr = {1'b0, cy} + (COORD_BITS+1)'(radius_q);

	always_comb begin
		if (cx < COORD_BITS'(radius_q))
			dx_c = COORD_BITS'({COORD_BITS'(radius_q) - cx, 1'b0} - 1'b1);
		else if (cxr >= {1'b0, rect_width_q})
			dx_c = COORD_BITS'({cxr - {1'b0, rect_width_q}, 1'b1});
		else
			dx_c = '0;
		if (cy < COORD_BITS'(radius_q))
			dy_c = COORD_BITS'({COORD_BITS'(radius_q) - cy, 1'b0} - 1'b1);
		else if (cyr >= {1'b0, rect_height_q})
			dy_c = COORD_BITS'({cyr - {1'b0, rect_height_q}, 1'b1});
		else
			dy_c = '0;
		mx = rect_width_q - 1'b1 - cx;
		if (cx < mx) mx = cx;
		my = rect_height_q - 1'b1 - cy;
		if (cy < my) my = cy;
		mm = (mx < my) ? mx : my;
		pix_c.in_range = (cx < rect_width_q) && (cy < rect_height_q);
		pix_c.sq_edge  = mm < COORD_BITS'(border_q);
		pix_c.both_pos = (dx_c != '0) && (dy_c != '0);
		pix_c.dmax     = (dx_c > dy_c) ? dx_c : dy_c;
		pix_c.dst      = s_tdata[2*COORD_BITS+31:2*COORD_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			pix_s1 <= pix_c;
		end
	end

	// ---------------- stage 2: squares
	logic [2*COORD_BITS-1:0] dx2_s2, dy2_s2;
	pix_t                    pix_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dx2_s2 <= dx_s1 * dx_s1;
			dy2_s2 <= dy_s1 * dy_s1;
			pix_s2 <= pix_s1;
		end
	end

	// ---------------- stage 3: sum of squares
	logic [SUM_W-1:0] sum_s3;
	pix_t             pix_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sum_s3 <= SUM_W'(dx2_s2) + SUM_W'(dy2_s2);
			pix_s3 <= pix_s2;
		end
	end

	// ---------------- stages 4..7: floor square root, four bits per stage
	logic [SUM_W-1:0] rem_sq_s  [SQ_STAGES+1];
	logic [SQ_W-1:0]  root_sq_s [SQ_STAGES+1];
	pix_t             pix_sq_s  [SQ_STAGES+1];

	assign rem_sq_s[0]  = sum_s3;
	assign root_sq_s[0] = '0;
	assign pix_sq_s[0]  = pix_s3;

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
		logic [SUM_W-1:0] rem_c;
		logic [SQ_W-1:0]  root_c;

		always_comb begin
			logic [TRY_W-1:0] t;
			int               b;
			rem_c  = rem_sq_s[j];
			root_c = root_sq_s[j];
			for (int i = 0; i < SQ_STEPS; i++) begin
				b = SQ_W - 1 - (j * SQ_STEPS + i);
				if (b >= 0) begin
					t = (TRY_W'(root_c) << (b + 1)) + (TRY_W'(1) << (2 * b));
					if ({1'b0, rem_c} >= t) begin
						rem_c  = rem_c - SUM_W'(t);
						root_c = root_c | (SQ_W'(1) << b);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[SQ0+j]) begin
				rem_sq_s[j+1]  <= rem_c;
				root_sq_s[j+1] <= root_c;
				pix_sq_s[j+1]  <= pix_sq_s[j];
			end
		end
	end

	// ---------------- stage 8: shape, color and coverage
	logic signed [SHAPE_W-1:0] shape, edge_lim;
	logic [SQ_W-1:0]           dist_c;
	logic                      rnd, r_edge, use_edge, we_c;
	logic [7:0]                a_c, a_base;
	logic [31:0]               color_c;
	pix_t                      pq;

	logic        we_s8;
	logic [7:0]  a_s8;
	logic [31:0] color_s8, dst_s8;

	always_comb begin
		pq       = pix_sq_s[SQ_STAGES];
		rnd      = radius_q != '0;
		dist_c   = pq.both_pos ? root_sq_s[SQ_STAGES] : SQ_W'(pq.dmax);
		shape    = $signed({2'b00, dist_c}) - $signed(SHAPE_W'({radius_q, 1'b0}));
		edge_lim = shape + $signed(SHAPE_W'({border_q, 1'b1}));
		r_edge   = (border_q != '0) && (edge_lim >= 0);
		use_edge = rnd ? r_edge : pq.sq_edge;
		color_c  = use_edge ? edge_q : fill_q;
		a_base   = color_c[31:24];
		a_c      = a_base;
		if (rnd) begin
			if (shape == -1)
				a_c = 8'(({2'b00, a_base} + {1'b0, a_base, 1'b0}) >> 2);
			else if (shape == 0)
				a_c = a_base >> 1;
			else if (shape == 1)
				a_c = a_base >> 2;
		end
		we_c = pq.in_range && !(rnd && (shape >= 2));
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			we_s8    <= we_c;
			a_s8     <= a_c;
			color_s8 <= color_c;
			dst_s8   <= pq.dst;
		end
	end

	// ---------------- stage 9: lane multiplies
	logic        we_s9, full_s9;
	logic [31:0] prb_s9, pg_s9, drb_s9, dg_s9, tcol_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			we_s9   <= we_s8 && (a_s8 != '0);
			full_s9 <= a_s8 == ALPHA_FULL;
			prb_s9  <= 32'(((color_s8 & RB_MASK) - (dst_s8 & RB_MASK)) * 32'(a_s8));
			pg_s9   <= 32'(((color_s8 & G_MASK) - (dst_s8 & G_MASK)) * 32'(a_s8));
			drb_s9  <= dst_s8 & RB_MASK;
			dg_s9   <= dst_s8 & G_MASK;
			tcol_s9 <= color_s8 & (RB_MASK | G_MASK);
		end
	end

	// ---------------- stage 10: lane add, output register
	logic [31:0] rb_c, g_c, px_c;
	logic        we_s10;
	logic [31:0] px_s10;

	always_comb begin
		rb_c = (prb_s9 >> 8) + drb_s9;
		g_c  = (pg_s9 >> 8) + dg_s9;
		px_c = full_s9 ? (ALPHA_FF | tcol_s9)
			: (ALPHA_FF | (rb_c & RB_MASK) | (g_c & G_MASK));
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			we_s10 <= we_s9;
			px_s10 <= we_s9 ? px_c : '0;
		end
	end

	assign m_tvalid = vld_s[NST];
	assign m_tuser  = we_s10;
	assign m_tdata  = px_s10;
endmodule
`default_nettype wire

@@ tb/rounded_rect_alpha_blend_chk.sv @@
// Checker for rounded_rect_alpha_blend: watches the pixel and result streams,
// predicts each result from its own copy of the registers, compares in order.
// Depends on rrab_pkg.
`timescale 1ns / 100ps
module rounded_rect_alpha_blend_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rrab_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [rrab_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rrab_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [31:0]                     m_tdata,
	input  logic                            m_tuser,
	output int                              fail_count,
	output int                              pending
);
	import rrab_pkg::*;

	logic [11:0] width_q, height_q;
	logic [10:0] radius_q, border_q;
	logic [31:0] fill_q, edge_q;
	logic [32:0] pixel_q[$];

	assign pending = pixel_q.size();

	function automatic longint isqrt(longint n);
		longint root;
		root = 0;
		for (int b = 20; b >= 0; b--)
			if ((root + (64'd1 << b)) * (root + (64'd1 << b)) <= n)
				root = root + (64'd1 << b);
		return root;
	endfunction

	function automatic longint corner_dist(longint c, longint len, longint r);
		if (c < r)
			return 2 * r - (2 * c + 1);
		if (c >= len - r)
			return (2 * c + 1) - 2 * (len - r);
		return 0;
	endfunction

	// returns {write_enable, new_pixel}
	function automatic logic [32:0] shade_pixel(longint cx, longint cy, logic [31:0] dst);
		longint w, h, r, bt, dx, dy, cdist, shape, mx, my, m;
		logic [31:0] color, trb, tg, drb, dg, rb, g;
		int unsigned a, cov;
		w = longint'(width_q); h = longint'(height_q);
		r = longint'(radius_q); bt = longint'(border_q);
		if (cx >= w || cy >= h)
			return 33'd0;
		if (r > 0) begin
			dx = corner_dist(cx, w, r);
			dy = corner_dist(cy, h, r);
			if (dx > 0 && dy > 0)
				cdist = isqrt(dx * dx + dy * dy);
			else
				cdist = dx > dy ? dx : dy;
			shape = cdist - 2 * r;
			if (shape >= 2)
				return 33'd0;
			color = (bt > 0 && shape >= -2 * bt - 1) ? edge_q : fill_q;
			a = 32'(color[31:24]);
			if (shape > -2) begin
				cov = 32'(255 - ((shape + 2) * 255) / 4);
				a = (a * cov) >> 8;
			end
		end else begin
			mx = cx < w - 1 - cx ? cx : w - 1 - cx;
			my = cy < h - 1 - cy ? cy : h - 1 - cy;
			m = mx < my ? mx : my;
			color = (m < bt) ? edge_q : fill_q;
			a = 32'(color[31:24]);
		end
		if (a == 0)
			return 33'd0;
		trb = color & RB_MASK;
		tg = color & G_MASK;
		if (a == 255)
			return {1'b1, ALPHA_FF | trb | tg};
		drb = dst & RB_MASK;
		dg = dst & G_MASK;
		rb = (((trb - drb) * a) >> 8) + drb;
		g = (((tg - dg) * a) >> 8) + dg;
		return {1'b1, ALPHA_FF | (rb & RB_MASK) | (g & G_MASK)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [32:0] want;
		if (!arst_n) begin
			width_q <= '0; height_q <= '0; radius_q <= '0; border_q <= '0;
			fill_q <= '0; edge_q <= '0;
			fail_count <= 0;
			pixel_q.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_RECT_WIDTH:  width_q <= cfg_wdata[11:0];
					REG_RECT_HEIGHT: height_q <= cfg_wdata[11:0];
					REG_RADIUS:      radius_q <= cfg_wdata[10:0];
					REG_BORDER:      border_q <= cfg_wdata[10:0];
					REG_FILL_COLOR:  fill_q <= cfg_wdata;
					REG_EDGE_COLOR:  edge_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pixel_q.push_back(shade_pixel(longint'(s_tdata[11:0]),
					longint'(s_tdata[23:12]), s_tdata[55:24]));
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result we=%b px=%h", m_tuser, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = pixel_q.pop_front();
					if (want != {m_tuser, m_tdata}) begin
						if (fail_count < 10)
							$display("mismatch: expected we=%b px=%h, got we=%b px=%h",
								want[32], want[31:0], m_tuser, m_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ tb/rounded_rect_alpha_blend_tb.sv @@
// Testbench top for rounded_rect_alpha_blend: drives pixels and register
// writes, stalls both streams in phases, and reports the verdict.
// Depends on rrab_pkg and rounded_rect_alpha_blend_chk.
`timescale 1ns / 100ps
module rounded_rect_alpha_blend_tb;
	import rrab_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tuser;
	int fail_count, pending;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;
	logic [11:0] cur_w, cur_h;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rounded_rect_alpha_blend uut (.*);
	rounded_rect_alpha_blend_chk chk (.*);

	always @(negedge clk)
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop the input and wait until every result has come out
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (14) @(negedge clk);
	endtask

	task automatic setup_rect(logic [11:0] w, logic [11:0] h, logic [10:0] r,
		logic [10:0] bt, logic [31:0] fc, logic [31:0] ec);
		drain_pipe();
		cur_w = w; cur_h = h;
		write_reg(REG_RECT_WIDTH, 32'(w));
		write_reg(REG_RECT_HEIGHT, 32'(h));
		write_reg(REG_RADIUS, 32'(r));
		write_reg(REG_BORDER, 32'(bt));
		write_reg(REG_FILL_COLOR, fc);
		write_reg(REG_EDGE_COLOR, ec);
	endtask

	// leaves tvalid high after the item; the next call replaces or drops it, drain_pipe drops it
	task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] dst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dst, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly inside the rectangle and near its edges, some anywhere
	function automatic logic [11:0] pick_coord(logic [11:0] len);
		case ($urandom_range(9))
			0: return 12'($urandom);
			1: return len;
			2, 3: return (len == 0) ? 12'd0 :
				12'($urandom_range(32'(len) - 1, len > 8 ? 32'(len) - 8 : 0));
			4, 5: return 12'($urandom_range(len > 8 ? 7 : 32'(len)));
			default: return (len == 0) ? 12'd0 : 12'($urandom_range(32'(len) - 1));
		endcase
	endfunction

	task automatic random_rect();
		logic [11:0] w, h;
		logic [10:0] r, bt;
		int cut;
		cut = $urandom_range(9);
		w = (cut == 0) ? 12'($urandom) : 12'($urandom_range(64));
		h = (cut == 0) ? 12'($urandom) : 12'($urandom_range(64));
		r = ($urandom_range(3) == 0) ? 11'd0 :
			(cut == 1 ? 11'($urandom) : 11'($urandom_range(40)));
		bt = ($urandom_range(3) == 0) ? 11'd0 :
			(cut == 2 ? 11'($urandom) : 11'($urandom_range(10)));
		setup_rect(w, h, r, bt, $urandom, $urandom);
	endtask

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		// reset values: zero size, every pixel misses
		send_pixel(0, 0, 32'hFFFFFFFF);
		setup_rect(12'd20, 12'd16, 11'd5, 11'd2, 32'h80FF8040, 32'hFF123456);
		send_pixel(0, 0, 32'h00000000);
		send_pixel(2, 2, 32'hFFFFFFFF);
		send_pixel(5, 0, 32'h11223344);
		send_pixel(10, 8, 32'hA5A5A5A5);
		send_pixel(19, 15, 32'h5A5A5A5A);
		send_pixel(20, 3, 32'hFFFFFFFF);
		send_pixel(3, 16, 32'hFFFFFFFF);
		send_pixel(12'hFFF, 12'hFFF, 32'hFFFFFFFF);
		setup_rect(12'hFFF, 12'hFFF, 11'h7FF, 11'h7FF, 32'hFFFFFFFF, 32'h00FFFFFF);
		send_pixel(0, 0, 32'h0);
		send_pixel(12'hFFE, 12'hFFE, 32'h0);
		send_pixel(2047, 2047, 32'hFFFFFFFF);
		send_pixel(0, 2047, 32'h12345678);
		setup_rect(12'd9, 12'd7, 11'd0, 11'd2, 32'h40FF0000, 32'hC000FF00);
		send_pixel(0, 3, 32'h0000FF00);
		send_pixel(4, 3, 32'hFF00FF00);
		send_pixel(8, 6, 32'h12345678);
		send_pixel(2, 2, 32'hFFFFFFFF);
		setup_rect(12'd9, 12'd7, 11'd0, 11'd0, 32'h00FF0000, 32'h00FF0000);
		send_pixel(4, 3, 32'hFFFFFFFF);
		setup_rect(12'd0, 12'd5, 11'd0, 11'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_pixel(0, 0, 32'hFFFFFFFF);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 30) : 0;
			recv_stall_pct = (ph == 2) ? 54 : (ph == 3 ? 30 : 0);
			for (int grp = 0; grp < 10; grp++) begin
				random_rect();
				for (int k = 0; k < 40; k++)
					send_pixel(pick_coord(cur_w), pick_coord(cur_h), $urandom);
				if (grp == 4) begin
					// sender pauses until the pipeline has emptied
					s_tvalid <= 1'b0;
					while (pending != 0)
						@(negedge clk);
				end
			end
			if (ph == 0) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (60) @(negedge clk);
						hold_off = 1'b0;
					end
					for (int k = 0; k < 30; k++)
						send_pixel(pick_coord(cur_w), pick_coord(cur_h), $urandom);
				join
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_pipe();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
